@@ rtl/multichannel_fir_filter_macros.svh @@
// ============================================================================
// multichannel_fir_filter_macros.svh
// Assertion macros for the multichannel FIR filter RTL.
// ============================================================================
`ifndef MULTICHANNEL_FIR_FILTER_MACROS_SVH
`define MULTICHANNEL_FIR_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (active-low reset).
`define MCFIR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MCFIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MCFIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCFIR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/mcfir_pkg.sv @@
// ============================================================================
// mcfir_pkg
// Shared constants and types for the multichannel FIR filter.
// ============================================================================
package mcfir_pkg;

    // Filter geometry
    localparam int TAPS     = 32;
    localparam int CHANNELS = 4;

    // Field widths
    localparam int CMD_W    = 1;
    localparam int CHAN_W   = 2;
    localparam int SAMP_W   = 24;
    localparam int CIDX_W   = 5;
    localparam int COEF_W   = 16;
    localparam int OUT_W    = 32;

    // Derived widths
    localparam int TAP_W     = $clog2(TAPS);
    localparam int TAP_CNT_W = $clog2(TAPS + 1);
    localparam int DLY_AW    = CHAN_W + TAP_W;
    localparam int DLY_DEPTH = 1 << DLY_AW;
    localparam int PROD_W    = COEF_W + SAMP_W;

    // Commands
    localparam logic [CMD_W-1:0] CMD_FILTER = 1'b0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b1;

    // Control from the sequencer to the MAC unit
    typedef struct packed {
        logic clear;      // zero the accumulator
        logic tap_valid;  // read data for one tap is present
        logic tap_last;   // that tap is the final one of the item
    } mac_ctrl_t;

endpackage

@@ rtl/mcfir_coef_mem.sv @@
// ============================================================================
// mcfir_coef_mem
// Shared coefficient table: one write port, one registered read port.
// Entries never written since reset read as zero.
// ============================================================================
module mcfir_coef_mem
    import mcfir_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [TAP_W-1:0]         wr_addr,
    input  logic signed [COEF_W-1:0] wr_data,
    input  logic [TAP_W-1:0]         rd_addr,
    output logic signed [COEF_W-1:0] rd_data
);

    logic signed [COEF_W-1:0] mem [TAPS];
    logic [TAPS-1:0]          vld_reg;
    logic signed [COEF_W-1:0] rd_data_reg;
    logic                     rd_vld_reg;

    // Storage array and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Per-entry written flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ rtl/mcfir_delay_mem.sv @@
// ============================================================================
// mcfir_delay_mem
// Sample delay lines of all channels in one synchronous RAM,
// addressed {channel, slot}, one write and one registered read per cycle.
// ============================================================================
module mcfir_delay_mem
    import mcfir_pkg::*;
(
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [DLY_AW-1:0]        wr_addr,
    input  logic signed [SAMP_W-1:0] wr_data,
    input  logic [DLY_AW-1:0]        rd_addr,
    output logic signed [SAMP_W-1:0] rd_data
);

    logic signed [SAMP_W-1:0] mem [DLY_DEPTH];
    logic signed [SAMP_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/mcfir_mac.sv @@
// ============================================================================
// mcfir_mac
// Multiply-accumulate unit: one registered product per tap, then a
// 32-bit wrapping accumulate. Raises done in the same cycle as the final sum reaches acc.
// ============================================================================
module mcfir_mac
    import mcfir_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mac_ctrl_t                ctrl,
    input  logic signed [COEF_W-1:0] coef,
    input  logic signed [SAMP_W-1:0] sample,
    output logic signed [OUT_W-1:0]  acc,
    output logic                     done
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OUT_W-1:0]  acc_reg;
    logic                     prod_vld_reg;
    logic                     prod_last_reg;
    logic                     done_reg;

    // Control pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            prod_vld_reg  <= ctrl.tap_valid;
            prod_last_reg <= ctrl.tap_valid & ctrl.tap_last;
            done_reg      <= prod_vld_reg & prod_last_reg;
        end
    end

    // Product and accumulator; sum wraps at 32 bits
    always_ff @(posedge aclk) begin
        if (ctrl.tap_valid) begin
            prod_reg <= coef * sample;
        end
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + prod_reg[OUT_W-1:0];
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

@@ rtl/multichannel_fir_filter.sv @@
// ============================================================================
// multichannel_fir_filter
// Four-channel FIR filter with one shared coefficient table, per-channel
// circular delay lines in RAM and one multiply-accumulate per tap.
// ============================================================================
//
//  Channel  Dir  Ports                                         Beat
//  s_*      in   command, channel, sample_value, coef_index,   coefficient load
//                coef_value                                    or one sample
//  m_*      out  filtered, out_channel                         one FIR sum
//
//  A coefficient load leaves s_ready high. A sample holds it low through the
//  write, run, drain and hold states: one delay RAM read port feeds the MAC.
//  Reset clears pointers and written flags; unwritten entries read as zero.
//  A result waits in the output register; only a second result stalls on it.
//
module multichannel_fir_filter
    import mcfir_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_command,
    input  logic [CHAN_W-1:0]        s_channel,
    input  logic signed [SAMP_W-1:0] s_sample_value,
    input  logic [CIDX_W-1:0]        s_coef_index,
    input  logic signed [COEF_W-1:0] s_coef_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [OUT_W-1:0]  m_filtered,
    output logic [CHAN_W-1:0]        m_out_channel
);

`include "multichannel_fir_filter_macros.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    localparam logic [TAP_W-1:0]     TAP_LAST  = TAP_W'(TAPS - 1);
    localparam logic [TAP_W:0]       TAPS_WIDE = (TAP_W + 1)'(TAPS);
    localparam logic [TAP_CNT_W-1:0] TAPS_CNT  = TAP_CNT_W'(TAPS);

    logic [2:0]               state_reg, state_next;
    logic [TAP_CNT_W-1:0]     tap_cnt_reg;
    logic [TAP_W-1:0]         wp_reg [CHANNELS];
    logic [CHANNELS-1:0]      full_reg;
    logic [TAP_W-1:0]         cur_wp_reg;
    logic                     cur_full_reg;
    logic [CHAN_W-1:0]        cur_ch_reg;
    logic signed [SAMP_W-1:0] cur_samp_reg;
    logic                     rd_vld_reg;
    logic                     rd_last_reg;
    logic                     rd_ok_reg;
    logic                     m_valid_reg;
    logic signed [OUT_W-1:0]  m_filtered_reg;
    logic [CHAN_W-1:0]        m_ch_reg;

    logic                     in_acc;
    logic                     chan_ok;
    logic                     coef_idx_ok;
    logic                     load_acc;
    logic                     filt_acc;
    logic [TAP_W-1:0]         tap_idx;
    logic [TAP_W-1:0]         rd_pos;
    logic                     rd_pos_ok;
    logic                     issue;
    logic                     issue_last;
    logic                     out_free;
    logic signed [COEF_W-1:0] coef_rd;
    logic signed [SAMP_W-1:0] dly_rd;
    logic signed [SAMP_W-1:0] mac_samp;
    logic signed [OUT_W-1:0]  mac_acc;
    logic                     mac_done;
    mac_ctrl_t                mac_ctrl;

    // Input decode
    assign s_ready     = (state_reg == ST_IDLE);
    assign in_acc      = s_valid & s_ready;
    assign chan_ok     = (int'(s_channel) < CHANNELS);
    assign coef_idx_ok = (int'(s_coef_index) < TAPS);
    assign load_acc    = in_acc & (s_command == CMD_LOAD) & coef_idx_ok;
    assign filt_acc    = in_acc & (s_command == CMD_FILTER) & chan_ok;

    // Tap read address: slot i steps back from the newest sample
    assign tap_idx = tap_cnt_reg[TAP_W-1:0];
    always_comb begin
        if (cur_wp_reg >= tap_idx) begin
            rd_pos = cur_wp_reg - tap_idx;
        end else begin
            rd_pos = TAP_W'({1'b0, cur_wp_reg} + TAPS_WIDE - {1'b0, tap_idx});
        end
    end
    assign rd_pos_ok  = cur_full_reg | (rd_pos <= cur_wp_reg);
    assign issue      = (state_reg == ST_RUN);
    assign issue_last = (tap_idx == TAP_LAST);
    assign out_free   = ~m_valid_reg | m_ready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (filt_acc) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tap_cnt_reg <= '0;
            full_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                wp_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;

            // Pointer advance and wrap tracking at sample accept
            if (filt_acc) begin
                wp_reg[s_channel] <= (wp_reg[s_channel] == TAP_LAST) ? '0
                                     : wp_reg[s_channel] + 1'b1;
                if (wp_reg[s_channel] == TAP_LAST) begin
                    full_reg[s_channel] <= 1'b1;
                end
            end

            // Tap counter
            if (state_reg == ST_WRITE) begin
                tap_cnt_reg <= '0;
            end else if (issue) begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
            end

            rd_vld_reg  <= issue;
            rd_last_reg <= issue & issue_last;

            // Output register
            if (state_reg == ST_HOLD && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (filt_acc) begin
            cur_ch_reg   <= s_channel;
            cur_samp_reg <= s_sample_value;
            cur_wp_reg   <= wp_reg[s_channel];
            cur_full_reg <= full_reg[s_channel] | (wp_reg[s_channel] == TAP_LAST);
        end
        rd_ok_reg <= rd_pos_ok;
        if (state_reg == ST_HOLD && out_free) begin
            m_filtered_reg <= mac_acc;
            m_ch_reg       <= cur_ch_reg;
        end
    end

    // Coefficient table
    mcfir_coef_mem u_coef_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_acc),
        .wr_addr (TAP_W'(s_coef_index)),
        .wr_data (s_coef_value),
        .rd_addr (tap_idx),
        .rd_data (coef_rd)
    );

    // Delay lines
    mcfir_delay_mem u_delay_mem (
        .aclk    (aclk),
        .wr_en   (state_reg == ST_WRITE),
        .wr_addr ({cur_ch_reg, cur_wp_reg}),
        .wr_data (cur_samp_reg),
        .rd_addr ({cur_ch_reg, rd_pos}),
        .rd_data (dly_rd)
    );

    // MAC
    assign mac_ctrl.clear     = (state_reg == ST_WRITE);
    assign mac_ctrl.tap_valid = rd_vld_reg;
    assign mac_ctrl.tap_last  = rd_last_reg;
    assign mac_samp           = rd_ok_reg ? dly_rd : '0;

    mcfir_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .coef    (coef_rd),
        .sample  (mac_samp),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    assign m_valid       = m_valid_reg;
    assign m_filtered    = m_filtered_reg;
    assign m_out_channel = m_ch_reg;

    // Checks
    `MCFIR_ASSERT(a_tap_cnt_range, aclk, aresetn, (state_reg == ST_RUN) |-> (tap_cnt_reg < TAPS_CNT), "tap counter past last tap")
    `MCFIR_ASSERT(a_filt_starts_write, aclk, aresetn, filt_acc |=> (state_reg == ST_WRITE), "sample beat did not start a write")
    `MCFIR_ASSERT(a_done_in_drain, aclk, aresetn, mac_done |-> (state_reg == ST_DRAIN), "MAC finished outside drain")
    `MCFIR_ASSERT(a_out_from_hold, aclk, aresetn, $rose(m_valid_reg) |-> ($past(state_reg) == ST_HOLD), "result raised outside hold")

endmodule
